/* rtl/assert_macros.svh */
// Assertion helpers shared by the checker files.
// Every assertion is clocked on the rising edge and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`endif

/* rtl/dwcs_pkg.sv */
`timescale 1ns / 1ps

package dwcs_pkg;

    // Field widths
    localparam int VEL_W      = 16;
    localparam int LIMIT_W    = 15;
    localparam int ACCEL_W    = 16;
    localparam int TSTEP_W    = 11;
    localparam int CNT_W      = 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam int MAX_LINEAR_SAMPLES  = 8;
    localparam int MAX_ANGULAR_SAMPLES = 8;
    localparam int IDX_W = $clog2(MAX_LINEAR_SAMPLES);
    localparam int REM_W = 3;   // divisor is count-1, at most 7

    // accel * time_step, then >> 10 gives the window half-width
    localparam int TIME_SHIFT = 10;
    localparam int PROD_W     = ACCEL_W + TSTEP_W;
    localparam int STEP_W     = PROD_W - TIME_SHIFT;
    localparam int WIDE_W     = VEL_W + 2;

    localparam logic [TSTEP_W-1:0] TS_MIN = TSTEP_W'(21);
    localparam logic [TSTEP_W-1:0] TS_MAX = TSTEP_W'(1024);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SPEED_LIMIT     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TURN_RATE_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_LIMIT     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ANG_ACCEL_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP       = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_ALLOWED = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_LINEAR_COUNT    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_ANGULAR_COUNT   = 3'd7;

    // Reset values
    localparam logic [LIMIT_W-1:0] RST_SPEED_LIMIT     = 15'd1024;
    localparam logic [LIMIT_W-1:0] RST_TURN_RATE_LIMIT = 15'd1024;
    localparam logic [ACCEL_W-1:0] RST_ACCEL_LIMIT     = 16'd1024;
    localparam logic [ACCEL_W-1:0] RST_ANG_ACCEL_LIMIT = 16'd1024;
    localparam logic [TSTEP_W-1:0] RST_TIME_STEP       = 11'd102;
    localparam logic               RST_REVERSE_ALLOWED = 1'b0;
    localparam logic [CNT_W-1:0]   RST_LINEAR_COUNT    = 4'd5;
    localparam logic [CNT_W-1:0]   RST_ANGULAR_COUNT   = 4'd5;

    // Effective configuration (time step and counts already saturated)
    typedef struct packed {
        logic [LIMIT_W-1:0] speed_limit;
        logic [LIMIT_W-1:0] turn_rate_limit;
        logic [ACCEL_W-1:0] accel_limit;
        logic [ACCEL_W-1:0] angular_accel_limit;
        logic [TSTEP_W-1:0] time_step;
        logic               reverse_allowed;
        logic [CNT_W-1:0]   linear_count;
        logic [CNT_W-1:0]   angular_count;
    } cfg_t;

    // Operands for one axis window
    typedef struct packed {
        logic signed [VEL_W-1:0] cur;
        logic [ACCEL_W-1:0]      accel;
        logic [TSTEP_W-1:0]      time_step;
        logic signed [VEL_W-1:0] floor_v;
        logic signed [VEL_W-1:0] ceil_v;
        logic [CNT_W-1:0]        count;
    } win_req_t;

    // Sample i = lo + i*quot + floor(i*rem/den)
    typedef struct packed {
        logic signed [VEL_W-1:0] lo;
        logic [VEL_W-1:0]        quot;
        logic [REM_W-1:0]        rem;
        logic [REM_W-1:0]        den;
        logic [CNT_W-1:0]        num;
    } win_res_t;

    // Running sample value and remainder accumulator of one axis
    typedef struct packed {
        logic signed [VEL_W-1:0] val;
        logic [REM_W-1:0]        racc;
    } adv_t;

endpackage

/* rtl/dwcs_cfg_regs.sv */
`timescale 1ns / 1ps

module dwcs_cfg_regs
    import dwcs_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output cfg_t                  cfg
);

    logic [LIMIT_W-1:0] speed_reg;
    logic [LIMIT_W-1:0] turn_reg;
    logic [ACCEL_W-1:0] accel_reg;
    logic [ACCEL_W-1:0] ang_accel_reg;
    logic [TSTEP_W-1:0] tstep_reg;
    logic               reverse_reg;
    logic [CNT_W-1:0]   lin_cnt_reg;
    logic [CNT_W-1:0]   ang_cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            speed_reg     <= RST_SPEED_LIMIT;
            turn_reg      <= RST_TURN_RATE_LIMIT;
            accel_reg     <= RST_ACCEL_LIMIT;
            ang_accel_reg <= RST_ANG_ACCEL_LIMIT;
            tstep_reg     <= RST_TIME_STEP;
            reverse_reg   <= RST_REVERSE_ALLOWED;
            lin_cnt_reg   <= RST_LINEAR_COUNT;
            ang_cnt_reg   <= RST_ANGULAR_COUNT;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SPEED_LIMIT:     speed_reg     <= cfg_data[LIMIT_W-1:0];
                REG_TURN_RATE_LIMIT: turn_reg      <= cfg_data[LIMIT_W-1:0];
                REG_ACCEL_LIMIT:     accel_reg     <= cfg_data[ACCEL_W-1:0];
                REG_ANG_ACCEL_LIMIT: ang_accel_reg <= cfg_data[ACCEL_W-1:0];
                REG_TIME_STEP:       tstep_reg     <= cfg_data[TSTEP_W-1:0];
                REG_REVERSE_ALLOWED: reverse_reg   <= cfg_data[0];
                REG_LINEAR_COUNT:    lin_cnt_reg   <= cfg_data[CNT_W-1:0];
                REG_ANGULAR_COUNT:   ang_cnt_reg   <= cfg_data[CNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Saturate a count to [1, max]
    function automatic logic [CNT_W-1:0] sat_count(logic [CNT_W-1:0] c, int maxc);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (c > CNT_W'(maxc))
            r = CNT_W'(maxc);
        else
            r = c;
        return r;
    endfunction

    always_comb
    begin
        cfg.speed_limit         = speed_reg;
        cfg.turn_rate_limit     = turn_reg;
        cfg.accel_limit         = accel_reg;
        cfg.angular_accel_limit = ang_accel_reg;
        cfg.reverse_allowed     = reverse_reg;
        if (tstep_reg < TS_MIN)
            cfg.time_step = TS_MIN;
        else if (tstep_reg > TS_MAX)
            cfg.time_step = TS_MAX;
        else
            cfg.time_step = tstep_reg;
        cfg.linear_count  = sat_count(lin_cnt_reg, MAX_LINEAR_SAMPLES);
        cfg.angular_count = sat_count(ang_cnt_reg, MAX_ANGULAR_SAMPLES);
    end

endmodule

/* rtl/dwcs_window_unit.sv */
`timescale 1ns / 1ps

// Shared window engine: multiply, clamp, then a bit-serial divide of the
// window span by count-1 unless single_case is set. Used once per axis.
module dwcs_window_unit
    import dwcs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  win_req_t req,
    output logic     done,
    output win_res_t res
);

    localparam logic [2:0] U_IDLE = 3'd0;
    localparam logic [2:0] U_MUL  = 3'd1;
    localparam logic [2:0] U_WIN  = 3'd2;
    localparam logic [2:0] U_CHK  = 3'd3;
    localparam logic [2:0] U_DIV  = 3'd4;

    localparam logic [3:0] DIV_LAST = 4'(VEL_W - 1);

    logic [2:0]              state_reg;
    logic                    done_reg;
    logic [3:0]              it_reg;
    logic [PROD_W-1:0]       prod_reg;
    logic signed [VEL_W-1:0] lo_reg;
    logic signed [VEL_W-1:0] hi_reg;
    logic [VEL_W-1:0]        sh_reg;
    logic [REM_W-1:0]        pr_reg;
    win_res_t                res_reg;

    logic [STEP_W-1:0]        step;
    logic signed [WIDE_W-1:0] cur_x;
    logic signed [WIDE_W-1:0] floor_x;
    logic signed [WIDE_W-1:0] ceil_x;
    logic signed [WIDE_W-1:0] lo_cl;
    logic signed [WIDE_W-1:0] hi_cl;
    logic signed [WIDE_W-1:0] single_v;
    logic                     single_case;
    logic [VEL_W:0]           span;
    logic [REM_W-1:0]         den;
    logic [REM_W:0]           trial;
    logic                     qbit;
    logic [REM_W-1:0]         pr_next;
    logic [VEL_W-1:0]         sh_next;

    function automatic logic signed [WIDE_W-1:0] bound(logic signed [WIDE_W-1:0] x,
                                                       logic signed [WIDE_W-1:0] lo,
                                                       logic signed [WIDE_W-1:0] hi);
        logic signed [WIDE_W-1:0] m;
        m = (x < hi) ? x : hi;
        return (m > lo) ? m : lo;
    endfunction

    always_comb
    begin
        step    = prod_reg[PROD_W-1 -: STEP_W];
        cur_x   = WIDE_W'(req.cur);
        floor_x = WIDE_W'(req.floor_v);
        ceil_x  = WIDE_W'(req.ceil_v);
        lo_cl   = bound(cur_x - $signed({2'b00, step[STEP_W-2:0]}) - (step[STEP_W-1] ?
                        $signed(WIDE_W'(1) <<< (STEP_W-1)) : '0), floor_x, ceil_x);
        hi_cl   = bound(cur_x + $signed({2'b00, step[STEP_W-2:0]}) + (step[STEP_W-1] ?
                        $signed(WIDE_W'(1) <<< (STEP_W-1)) : '0), floor_x, ceil_x);
        single_v    = bound(cur_x, WIDE_W'(lo_reg), WIDE_W'(hi_reg));
        single_case = (req.count <= CNT_W'(1)) || (hi_reg == lo_reg);
        span        = (VEL_W+1)'($signed({hi_reg[VEL_W-1], hi_reg})
                                 - $signed({lo_reg[VEL_W-1], lo_reg}));
        den         = REM_W'(req.count - CNT_W'(1));
        // one restoring-divide step
        trial   = {pr_reg, sh_reg[VEL_W-1]};
        qbit    = (trial >= {1'b0, res_reg.den});
        pr_next = qbit ? REM_W'(trial - {1'b0, res_reg.den}) : trial[REM_W-1:0];
        sh_next = {sh_reg[VEL_W-2:0], qbit};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= U_IDLE;
            done_reg  <= 1'b0;
            it_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            unique case (state_reg)
                U_IDLE:
                begin
                    if (start)
                        state_reg <= U_MUL;
                end
                U_MUL:
                begin
                    state_reg <= U_WIN;
                end
                U_WIN:
                begin
                    state_reg <= U_CHK;
                end
                U_CHK:
                begin
                    it_reg <= '0;
                    if (single_case)
                    begin
                        state_reg <= U_IDLE;
                        done_reg  <= 1'b1;
                    end
                    else
                        state_reg <= U_DIV;
                end
                U_DIV:
                begin
                    it_reg <= it_reg + 4'd1;
                    if (it_reg == DIV_LAST)
                    begin
                        state_reg <= U_IDLE;
                        done_reg  <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= U_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            U_MUL:
            begin
                prod_reg <= PROD_W'(req.accel) * PROD_W'(req.time_step);
            end
            U_WIN:
            begin
                lo_reg <= lo_cl[VEL_W-1:0];
                hi_reg <= hi_cl[VEL_W-1:0];
            end
            U_CHK:
            begin
                if (single_case)
                begin
                    res_reg.lo   <= single_v[VEL_W-1:0];
                    res_reg.quot <= '0;
                    res_reg.rem  <= '0;
                    res_reg.den  <= REM_W'(1);
                    res_reg.num  <= CNT_W'(1);
                end
                else
                begin
                    res_reg.lo  <= lo_reg;
                    res_reg.den <= den;
                    res_reg.num <= req.count;
                    sh_reg      <= span[VEL_W-1:0];
                    pr_reg      <= '0;
                end
            end
            U_DIV:
            begin
                sh_reg <= sh_next;
                pr_reg <= pr_next;
                if (it_reg == DIV_LAST)
                begin
                    res_reg.quot <= sh_next;
                    res_reg.rem  <= pr_next;
                end
            end
            default: ;
        endcase
    end

    assign done = done_reg;
    assign res  = res_reg;

endmodule

/* rtl/dynamic_window_command_sampler.sv */
`timescale 1ns / 1ps

// Dynamic-window command sampler. Each accepted item (lin_vel, ang_vel)
// produces a grid of candidate commands in linear-major order, linear index
// outer and angular index inner, with last_cmd set on the final one. Each axis
// window is current +/- ((accel * time_step) >> 10), clamped to the axis limits;
// samples are spread as lo + floor(i*(hi-lo)/(count-1)), and an axis with one
// sample or an empty window gives the current value clamped into the window.
// Each item occupies the block for a setup (the shared window engine runs
// once per axis: multiply, clamp, then a bit-serial divide of the span by
// count-1; an axis with a single sample or an empty window skips the divide),
// followed by one candidate per cycle while out_ready is high, nv*nw in all.
// in_ready is high only between items. The next item
// may be taken while the final candidate still sits in the output register.
// Configuration writes take effect at once and are to be made while idle.
module dynamic_window_command_sampler
    import dwcs_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    // configuration write port
    input  logic                    cfg_we,
    input  logic [CFG_IDX_W-1:0]    cfg_index,
    input  logic [CFG_DATA_W-1:0]   cfg_data,
    // input items
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [VEL_W-1:0] lin_vel,
    input  logic signed [VEL_W-1:0] ang_vel,
    // result items
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic signed [VEL_W-1:0] cmd_v,
    output logic signed [VEL_W-1:0] cmd_omega,
    output logic                    last_cmd
);

    localparam logic [1:0] T_IDLE = 2'd0;
    localparam logic [1:0] T_VWIN = 2'd1;   // engine works on the linear axis
    localparam logic [1:0] T_WWIN = 2'd2;   // engine works on the angular axis
    localparam logic [1:0] T_EMIT = 2'd3;   // walk the grid

    cfg_t     cfg;
    win_req_t win_req;
    win_res_t win_res;
    logic     win_done;

    logic [1:0]              state_reg;
    logic                    start_reg;
    logic                    axis_w_reg;
    logic                    out_valid_reg;
    logic signed [VEL_W-1:0] cur_v_reg;
    logic signed [VEL_W-1:0] cur_w_reg;
    win_res_t                v_par_reg;
    win_res_t                w_par_reg;
    adv_t                    v_gen_reg;
    adv_t                    w_gen_reg;
    logic [IDX_W-1:0]        a_reg;
    logic [IDX_W-1:0]        b_reg;
    logic signed [VEL_W-1:0] cmd_v_reg;
    logic signed [VEL_W-1:0] cmd_w_reg;
    logic                    last_reg;

    logic in_acc;
    logic load;
    logic a_end;
    logic b_end;
    logic grid_end;
    adv_t v_step;
    adv_t w_step;

    dwcs_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Operands follow the axis select, which is stable for the whole run.
    always_comb
    begin
        if (axis_w_reg)
        begin
            win_req.cur       = cur_w_reg;
            win_req.accel     = cfg.angular_accel_limit;
            win_req.floor_v   = -$signed({1'b0, cfg.turn_rate_limit});
            win_req.ceil_v    = $signed({1'b0, cfg.turn_rate_limit});
            win_req.count     = cfg.angular_count;
        end
        else
        begin
            win_req.cur       = cur_v_reg;
            win_req.accel     = cfg.accel_limit;
            win_req.floor_v   = cfg.reverse_allowed ?
                                -$signed({1'b0, cfg.speed_limit}) : '0;
            win_req.ceil_v    = $signed({1'b0, cfg.speed_limit});
            win_req.count     = cfg.linear_count;
        end
        win_req.time_step = cfg.time_step;
    end

    dwcs_window_unit u_win (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_reg),
        .req   (win_req),
        .done  (win_done),
        .res   (win_res)
    );

    // Next sample of an axis: add the integer step, carry from the remainder.
    function automatic adv_t axis_step(adv_t g, win_res_t p);
        logic [REM_W:0]    rs;
        logic              wrap;
        logic [WIDE_W-1:0] sum;
        adv_t              r;
        rs     = {1'b0, g.racc} + {1'b0, p.rem};
        wrap   = (rs >= {1'b0, p.den});
        sum    = WIDE_W'(g.val) + {2'b00, p.quot} + WIDE_W'(wrap);
        r.val  = sum[VEL_W-1:0];
        r.racc = wrap ? REM_W'(rs - {1'b0, p.den}) : rs[REM_W-1:0];
        return r;
    endfunction

    always_comb
    begin
        in_acc   = in_valid && in_ready;
        load     = (state_reg == T_EMIT) && (!out_valid_reg || out_ready);
        a_end    = ({1'b0, a_reg} == (v_par_reg.num - CNT_W'(1)));
        b_end    = ({1'b0, b_reg} == (w_par_reg.num - CNT_W'(1)));
        grid_end = a_end && b_end;
        v_step   = axis_step(v_gen_reg, v_par_reg);
        w_step   = axis_step(w_gen_reg, w_par_reg);
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= T_IDLE;
            start_reg     <= 1'b0;
            axis_w_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
            a_reg         <= '0;
            b_reg         <= '0;
        end
        else
        begin
            start_reg <= 1'b0;
            if (load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                T_IDLE:
                begin
                    if (in_acc)
                    begin
                        start_reg  <= 1'b1;
                        axis_w_reg <= 1'b0;
                        state_reg  <= T_VWIN;
                    end
                end
                T_VWIN:
                begin
                    if (win_done)
                    begin
                        start_reg  <= 1'b1;
                        axis_w_reg <= 1'b1;
                        state_reg  <= T_WWIN;
                    end
                end
                T_WWIN:
                begin
                    if (win_done)
                    begin
                        a_reg     <= '0;
                        b_reg     <= '0;
                        state_reg <= T_EMIT;
                    end
                end
                T_EMIT:
                begin
                    if (load)
                    begin
                        if (grid_end)
                            state_reg <= T_IDLE;
                        else if (b_end)
                        begin
                            b_reg <= '0;
                            a_reg <= a_reg + IDX_W'(1);
                        end
                        else
                            b_reg <= b_reg + IDX_W'(1);
                    end
                end
                default:
                begin
                    state_reg <= T_IDLE;
                end
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            cur_v_reg <= lin_vel;
            cur_w_reg <= ang_vel;
        end
        if (state_reg == T_VWIN && win_done)
            v_par_reg <= win_res;
        if (state_reg == T_WWIN && win_done)
        begin
            w_par_reg      <= win_res;
            v_gen_reg.val  <= v_par_reg.lo;
            v_gen_reg.racc <= '0;
            w_gen_reg.val  <= win_res.lo;
            w_gen_reg.racc <= '0;
        end
        if (load)
        begin
            cmd_v_reg <= v_gen_reg.val;
            cmd_w_reg <= w_gen_reg.val;
            last_reg  <= grid_end;
            if (b_end)
            begin
                // end of a row: angular restarts, linear moves on
                w_gen_reg.val  <= w_par_reg.lo;
                w_gen_reg.racc <= '0;
                v_gen_reg      <= v_step;
            end
            else
                w_gen_reg <= w_step;
        end
    end

    assign in_ready  = (state_reg == T_IDLE);
    assign out_valid = out_valid_reg;
    assign cmd_v     = cmd_v_reg;
    assign cmd_omega = cmd_w_reg;
    assign last_cmd  = last_reg;

endmodule

/* rtl/dwcs_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module dwcs_checker
    import dwcs_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    in_valid,
    input logic                    in_ready,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic signed [VEL_W-1:0] cmd_v,
    input logic signed [VEL_W-1:0] cmd_omega,
    input logic                    last_cmd
);

    // A stalled result stays offered.
    `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)

    // A stalled result keeps its payload.
    `ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable(cmd_v) && $stable(cmd_omega) && $stable(last_cmd))

    // An accepted item starts the setup, so the input closes at once.
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)

    // Candidates never reach the most negative code.
    `ASSERT_SAME(a_cmd_range, clk, rst_n, out_valid, (cmd_v != 16'sh8000) && (cmd_omega != 16'sh8000))

endmodule

bind dynamic_window_command_sampler dwcs_checker u_checker (.*);
